/* rtl/psd_pkg.sv */
// shared types and constants for the point to segment distance unit
// no dependencies
package psd_pkg;

  localparam int unsigned DIST_WIDTH   = 25;
  localparam int unsigned REGION_WIDTH = 2;

  typedef enum logic [REGION_WIDTH-1:0] {
    REGION_A   = 2'd0,
    REGION_B   = 2'd1,
    REGION_MID = 2'd2
  } region_e;

endpackage

/* rtl/psd_div_cell.sv */
// one restoring divide step for the x and y lanes, one quotient bit each
// depends on psd_pkg
module psd_div_cell import psd_pkg::*; #(
  parameter int unsigned LW = 33,
  parameter int unsigned QW = 16,
  parameter int unsigned SW = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [LW-1:0]          den_i,
  input  logic [1:0][LW-1:0]     rem_i,
  input  logic [1:0][QW-1:0]     quo_i,
  input  logic [SW-1:0]          side_i,
  output logic                   valid_o,
  output logic [LW-1:0]          den_o,
  output logic [1:0][LW-1:0]     rem_o,
  output logic [1:0][QW-1:0]     quo_o,
  output logic [SW-1:0]          side_o
);

  logic [1:0][LW-1:0] rem_d;
  logic [1:0][QW-1:0] quo_d;

  always_comb begin
    logic [LW:0] trial;
    logic [LW:0] diff;
    logic        ge;
    for (int k = 0; k < 2; k++) begin
      trial    = {rem_i[k], quo_i[k][QW-1]};
      diff     = trial - {1'b0, den_i};
      ge       = (trial >= {1'b0, den_i});
      rem_d[k] = ge ? diff[LW-1:0] : trial[LW-1:0];
      quo_d[k] = {quo_i[k][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_o  <= den_i;
      rem_o  <= rem_d;
      quo_o  <= quo_d;
      side_o <= side_i;
    end
  end

endmodule

/* rtl/psd_sqrt_cell.sv */
// one digit-by-digit square root step, one root bit
// depends on psd_pkg
module psd_sqrt_cell import psd_pkg::*; #(
  parameter int unsigned RW = 26,
  parameter int unsigned SW = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [RW+1:0]   rem_i,
  input  logic [RW-1:0]   root_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [2*RW-1:0] rad_o,
  output logic [RW+1:0]   rem_o,
  output logic [RW-1:0]   root_o,
  output logic [SW-1:0]   side_o
);

  logic [RW+1:0] rem_d;
  logic [RW-1:0] root_d;

  always_comb begin
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    logic          ge;
    cur    = {rem_i[RW-1:0], rad_i[2*RW-1:2*RW-2]};
    trial  = {root_i, 2'b01};
    ge     = (cur >= trial);
    rem_d  = ge ? (cur - trial) : cur;
    root_d = {root_i[RW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[2*RW-3:0], 2'b00};
      rem_o  <= rem_d;
      root_o <= root_d;
      side_o <= side_i;
    end
  end

endmodule

/* rtl/point_segment_distance_unit.sv */
// top level of the point to segment distance unit: front end, divider and root chains
// depends on psd_pkg, psd_div_cell, psd_sqrt_cell
//
// Streams one item per cycle while in_stall_o is low. Each item (point P,
// segment A-B) gives one result item: floor(|P - N| * 2^FRAC_BITS) and the
// region of the nearest point N. The pipeline is 4 front-end stages +
// COORD_BITS divider cells + 3 stages + (COORD_BITS + 2 + FRAC_BITS) root
// cells + 1 output register. The divider chain gives one quotient bit per
// cell and the root chain one root bit per cell, so the lengths of those two
// chains set the latency; throughput is one item per cycle while in_stall_o
// is low. A two-entry output (register plus skid) keeps accepting items while
// a finished result waits; in_stall_o rises only when both entries are full.
module point_segment_distance_unit import psd_pkg::*; #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] point_x_i,
  input  logic [COORD_BITS-1:0] point_y_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DIST_WIDTH-1:0] distance_q8_o,
  output logic [1:0]            nearest_region_o
);

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned LW  = 2*C + 1;          // squared length width
  localparam int unsigned QW  = C;                // quotient width
  localparam int unsigned NW  = LW + C;           // numerator width
  localparam int unsigned EW  = C + 2;            // error vector width
  localparam int unsigned DW  = 2*C + 4;          // squared distance width
  localparam int unsigned RW  = C + 2 + FRAC_BITS;
  localparam int unsigned SBW = 4*(C+1) + 4;      // divider sideband
  localparam int unsigned XW  = (RW > DIST_WIDTH) ? RW : DIST_WIDTH;

  // pipeline advances unless the skid entry is occupied
  logic pipe_en;
  logic skid_v_q;
  assign pipe_en    = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // stage 1: differences
  logic                v1_q;
  logic signed [C:0]   ux1_q, uy1_q, sx1_q, sy1_q, wx1_q, wy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (pipe_en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      ux1_q <= $signed({point_x_i[C-1], point_x_i}) - $signed({start_x_i[C-1], start_x_i});
      uy1_q <= $signed({point_y_i[C-1], point_y_i}) - $signed({start_y_i[C-1], start_y_i});
      sx1_q <= $signed({end_x_i[C-1], end_x_i}) - $signed({start_x_i[C-1], start_x_i});
      sy1_q <= $signed({end_y_i[C-1], end_y_i}) - $signed({start_y_i[C-1], start_y_i});
      wx1_q <= $signed({point_x_i[C-1], point_x_i}) - $signed({end_x_i[C-1], end_x_i});
      wy1_q <= $signed({point_y_i[C-1], point_y_i}) - $signed({end_y_i[C-1], end_y_i});
    end
  end

  // stage 2: products for dot and squared length
  logic                  v2_q;
  logic signed [2*C+1:0] pdx2_q, pdy2_q, plx2_q, ply2_q;
  logic signed [C:0]     ux2_q, uy2_q, wx2_q, wy2_q;
  logic                  sgnx2_q, sgny2_q;
  logic [C-1:0]          magx2_q, magy2_q;
  logic signed [C:0]     negx1, negy1;

  assign negx1 = -sx1_q;
  assign negy1 = -sy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (pipe_en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      pdx2_q  <= ux1_q * sx1_q;
      pdy2_q  <= uy1_q * sy1_q;
      plx2_q  <= sx1_q * sx1_q;
      ply2_q  <= sy1_q * sy1_q;
      ux2_q   <= ux1_q;
      uy2_q   <= uy1_q;
      wx2_q   <= wx1_q;
      wy2_q   <= wy1_q;
      sgnx2_q <= sx1_q[C];
      sgny2_q <= sy1_q[C];
      magx2_q <= sx1_q[C] ? negx1[C-1:0] : sx1_q[C-1:0];
      magy2_q <= sy1_q[C] ? negy1[C-1:0] : sy1_q[C-1:0];
    end
  end

  // stage 3: dot, length, region decision
  logic signed [2*C+2:0] dot2;
  logic [2*C+2:0]        len2;
  region_e               region2;

  assign dot2 = {pdx2_q[2*C+1], pdx2_q} + {pdy2_q[2*C+1], pdy2_q};
  assign len2 = {plx2_q[2*C+1], plx2_q} + {ply2_q[2*C+1], ply2_q};

  always_comb begin
    if (len2 == '0 || dot2[2*C+2]) begin
      region2 = REGION_A;
    end else if ($unsigned(dot2) > len2) begin
      region2 = REGION_B;
    end else begin
      region2 = REGION_MID;
    end
  end

  logic              v3_q;
  logic [LW-1:0]     dot3_q, len3_q;
  region_e           region3_q;
  logic signed [C:0] ux3_q, uy3_q, wx3_q, wy3_q;
  logic              sgnx3_q, sgny3_q;
  logic [C-1:0]      magx3_q, magy3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (pipe_en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dot3_q    <= dot2[LW-1:0];
      len3_q    <= len2[LW-1:0];
      region3_q <= region2;
      ux3_q     <= ux2_q;
      uy3_q     <= uy2_q;
      wx3_q     <= wx2_q;
      wy3_q     <= wy2_q;
      sgnx3_q   <= sgnx2_q;
      sgny3_q   <= sgny2_q;
      magx3_q   <= magx2_q;
      magy3_q   <= magy2_q;
    end
  end

  // stage 4: numerators dot * |s|
  logic               v4_q;
  logic [NW-1:0]      numx4_q, numy4_q;
  logic [LW-1:0]      den4_q;
  logic [SBW-1:0]     side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (pipe_en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      numx4_q <= NW'(dot3_q) * NW'(magx3_q);
      numy4_q <= NW'(dot3_q) * NW'(magy3_q);
      den4_q  <= len3_q;
      side4_q <= {region3_q, sgnx3_q, sgny3_q, ux3_q, uy3_q, wx3_q, wy3_q};
    end
  end

  // divider chain, one quotient bit per cell
  logic                 dv    [QW+1];
  logic [LW-1:0]        dden  [QW+1];
  logic [1:0][LW-1:0]   drem  [QW+1];
  logic [1:0][QW-1:0]   dquo  [QW+1];
  logic [SBW-1:0]       dside [QW+1];

  assign dv[0]      = v4_q;
  assign dden[0]    = den4_q;
  assign drem[0][0] = numx4_q[NW-1:QW];
  assign drem[0][1] = numy4_q[NW-1:QW];
  assign dquo[0][0] = numx4_q[QW-1:0];
  assign dquo[0][1] = numy4_q[QW-1:0];
  assign dside[0]   = side4_q;

  for (genvar i = 0; i < QW; i++) begin : g_div
    psd_div_cell #(.LW(LW), .QW(QW), .SW(SBW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (dv[i]),
      .den_i   (dden[i]),
      .rem_i   (drem[i]),
      .quo_i   (dquo[i]),
      .side_i  (dside[i]),
      .valid_o (dv[i+1]),
      .den_o   (dden[i+1]),
      .rem_o   (drem[i+1]),
      .quo_o   (dquo[i+1]),
      .side_o  (dside[i+1])
    );
  end

  // stage E: error vector P - N
  region_e           regione;
  logic              sgnxe, sgnye;
  logic signed [C:0] uxe, uye, wxe, wye;
  logic signed [EW-1:0] qxe, qye, exe, eye;

  assign {regione, sgnxe, sgnye, uxe, uye, wxe, wye} = dside[QW];
  assign qxe = $signed({2'b00, dquo[QW][0]});
  assign qye = $signed({2'b00, dquo[QW][1]});

  always_comb begin
    case (regione)
      REGION_A: begin
        exe = EW'(uxe);
        eye = EW'(uye);
      end
      REGION_B: begin
        exe = EW'(wxe);
        eye = EW'(wye);
      end
      REGION_MID: begin
        exe = sgnxe ? (EW'(uxe) + qxe) : (EW'(uxe) - qxe);
        eye = sgnye ? (EW'(uye) + qye) : (EW'(uye) - qye);
      end
      default: begin
        exe = EW'(uxe);
        eye = EW'(uye);
      end
    endcase
  end

  logic                 ve_q;
  logic signed [EW-1:0] ex_q, ey_q;
  region_e              regione_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (pipe_en) begin
      ve_q <= dv[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      ex_q      <= exe;
      ey_q      <= eye;
      regione_q <= regione;
    end
  end

  // stage S: squares
  logic                   vs_q;
  logic signed [2*EW-1:0] sqx_q, sqy_q;
  region_e                regions_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
    end else if (pipe_en) begin
      vs_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sqx_q     <= ex_q * ex_q;
      sqy_q     <= ey_q * ey_q;
      regions_q <= regione_q;
    end
  end

  // stage R: squared distance, scaled for the fraction bits
  logic            vr_q;
  logic [2*RW-1:0] rad_q;
  logic [1:0]      regionr_q;
  logic [DW-1:0]   d2s;

  assign d2s = DW'($unsigned(sqx_q)) + DW'($unsigned(sqy_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else if (pipe_en) begin
      vr_q <= vs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      rad_q     <= (2*RW)'(d2s) << (2*FRAC_BITS);
      regionr_q <= regions_q;
    end
  end

  // square root chain, one root bit per cell
  logic            sv    [RW+1];
  logic [2*RW-1:0] srad  [RW+1];
  logic [RW+1:0]   srem  [RW+1];
  logic [RW-1:0]   sroot [RW+1];
  logic [1:0]      sside [RW+1];

  assign sv[0]    = vr_q;
  assign srad[0]  = rad_q;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign sside[0] = regionr_q;

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    psd_sqrt_cell #(.RW(RW), .SW(2)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (sv[j]),
      .rad_i   (srad[j]),
      .rem_i   (srem[j]),
      .root_i  (sroot[j]),
      .side_i  (sside[j]),
      .valid_o (sv[j+1]),
      .rad_o   (srad[j+1]),
      .rem_o   (srem[j+1]),
      .root_o  (sroot[j+1]),
      .side_o  (sside[j+1])
    );
  end

  // output register plus skid entry
  logic                  tail_v;
  logic [XW-1:0]         tail_ext;
  logic [DIST_WIDTH-1:0] tail_dist;
  logic                  out_v_q;
  logic [DIST_WIDTH-1:0] out_dist_q, skid_dist_q;
  logic [1:0]            out_reg_q, skid_reg_q;
  logic                  take;

  assign tail_v    = sv[RW];
  assign tail_ext  = XW'(sroot[RW]);
  assign tail_dist = tail_ext[DIST_WIDTH-1:0];
  assign take      = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || take) begin
      out_v_q <= tail_v;
    end else if (tail_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_dist_q <= skid_dist_q;
        out_reg_q  <= skid_reg_q;
      end
    end else if (!out_v_q || take) begin
      out_dist_q <= tail_dist;
      out_reg_q  <= sside[RW];
    end else begin
      skid_dist_q <= tail_dist;
      skid_reg_q  <= sside[RW];
    end
  end

  assign out_valid_o      = out_v_q;
  assign distance_q8_o    = out_dist_q;
  assign nearest_region_o = out_reg_q;

  // skid holds an item only behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid entry full with empty output");

  // a taken output drains the skid into the output register
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !out_stall_i |=> !skid_v_q && out_v_q)
    else $error("skid entry did not drain");

  // a frozen pipeline keeps its last item
  a_tail_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en && tail_v |=> tail_v) else $error("pipeline item lost while frozen");

endmodule

/* dv/testbench.sv */
// self-checking testbench for point_segment_distance_unit
// depends on psd_pkg and the rtl of the unit; queue-fed driver, clocked monitor
module testbench;
  import psd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned LATENCY    = 2*COORD_BITS + FRAC_BITS + 10;
  localparam int unsigned WATCHDOG   = 4000;
  localparam int unsigned HOLD_LEN   = 400;

  typedef struct {
    logic signed [COORD_BITS-1:0] px, py, ax, ay, bx, by;
  } query_t;

  typedef struct {
    logic [DIST_WIDTH-1:0] distance;
    region_e               region;
  } answer_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [COORD_BITS-1:0] px_d, py_d, ax_d, ay_d, bx_d, by_d;
  logic [DIST_WIDTH-1:0] dist_q;
  logic [1:0] region_q;

  query_t  pending_queries[$];
  answer_t expected_answers[$];
  int      phase;         // 0: sender light idle, 1: receiver light idle, 2: no idle
  logic    hold_req;      // asks the receiver for a long hold-off
  logic    in_taken;
  int      hold_cnt;
  int      quiet_cycles;
  int      errors;
  int      n_checked;
  int      region_seen[3];

  point_segment_distance_unit #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .point_x_i(px_d), .point_y_i(py_d), .start_x_i(ax_d), .start_y_i(ay_d),
    .end_x_i(bx_d), .end_y_i(by_d),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .distance_q8_o(dist_q), .nearest_region_o(region_q)
  );

  // exact nearest-point distance, integer only
  function automatic logic [63:0] scaled_offset(longint dot, longint s, longint len);
    logic [127:0] mag, q;
    mag = (s < 0) ? 128'(-s) : 128'(s);
    q = (128'(dot) * mag) / 128'(len);
    return (s < 0) ? -q[63:0] : q[63:0];
  endfunction

  function automatic answer_t predict_distance(query_t q);
    longint px, py, ax, ay, bx, by, ux, uy, sx, sy, dot, len, nx, ny, ex, ey;
    logic [127:0] sq;
    logic [63:0] root, cand;
    answer_t r;
    px = q.px; py = q.py; ax = q.ax; ay = q.ay; bx = q.bx; by = q.by;
    ux = px - ax; uy = py - ay;
    sx = bx - ax; sy = by - ay;
    dot = ux * sx + uy * sy;
    len = sx * sx + sy * sy;
    if (len == 0 || dot < 0) begin
      nx = ax; ny = ay; r.region = REGION_A;
    end else if (dot > len) begin
      nx = bx; ny = by; r.region = REGION_B;
    end else begin
      nx = ax + longint'(scaled_offset(dot, sx, len));
      ny = ay + longint'(scaled_offset(dot, sy, len));
      r.region = REGION_MID;
    end
    ex = px - nx; ey = py - ny;
    sq = 128'(ex * ex + ey * ey) << (2 * FRAC_BITS);
    root = '0;
    for (int k = 63; k >= 0; k--) begin
      cand = root | (64'd1 << k);
      if (128'(cand) * 128'(cand) <= sq) root = cand;
    end
    r.distance = root[DIST_WIDTH-1:0];
    return r;
  endfunction

  function automatic query_t make_query(int px, int py, int ax, int ay, int bx, int by);
    query_t q;
    q.px = COORD_BITS'(px); q.py = COORD_BITS'(py); q.ax = COORD_BITS'(ax);
    q.ay = COORD_BITS'(ay); q.bx = COORD_BITS'(bx); q.by = COORD_BITS'(by);
    return q;
  endfunction

  function automatic int rand_coord(int span);
    if (span >= 32768) return int'($signed(16'($urandom)));
    return $urandom_range(2 * span) - span;
  endfunction

  // random query: wide coordinates, small ones, collinear and degenerate shapes
  function automatic query_t random_query();
    query_t q;
    int span, pick, t;
    pick = $urandom_range(9);
    span = (pick < 4) ? 32768 : (pick < 7) ? 64 : 4;
    q = make_query(rand_coord(span), rand_coord(span), rand_coord(span),
                   rand_coord(span), rand_coord(span), rand_coord(span));
    if (pick == 7) begin
      q.bx = q.ax; q.by = q.ay;                // degenerate segment
    end else if (pick == 8) begin
      t = $urandom_range(2);                   // point on an endpoint
      if (t == 0) begin q.px = q.ax; q.py = q.ay; end
      else begin q.px = q.bx; q.py = q.by; end
    end
    return q;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // driver: payload only changes once the held item has been taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_queries.size() != 0 &&
          $urandom_range(99) >= ((phase == 0) ? 14 : (phase == 1) ? 88 : 0)) begin
        query_t q;
        q = pending_queries.pop_front();
        px_d <= q.px; py_d <= q.py; ax_d <= q.ax;
        ay_d <= q.ay; bx_d <= q.bx; by_d <= q.by;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with a long counted hold-off on request
  always @(negedge clk) begin
    if (hold_req && hold_cnt == 0) begin
      hold_cnt  <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_cnt > 1) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      if (hold_cnt == 1) hold_cnt <= -1;       // hold-off done, never again
      out_stall <= ($urandom_range(99) < ((phase == 0) ? 88 : (phase == 1) ? 14 : 0));
    end
  end

  // monitor: predict on input accept, check on output accept
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_answers.push_back(predict_distance(
          make_query($signed(px_d), $signed(py_d), $signed(ax_d),
                     $signed(ay_d), $signed(bx_d), $signed(by_d))));
      end
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: result with nothing expected: dist %0d region %0d",
                   $realtime, dist_q, region_q);
          errors++;
        end else begin
          answer_t e;
          e = expected_answers.pop_front();
          if (dist_q !== e.distance) begin
            $display("%0t: distance mismatch: expected %0d actual %0d",
                     $realtime, e.distance, dist_q);
            errors++;
          end
          if (region_q !== e.region) begin
            $display("%0t: region mismatch: expected %0d actual %0d",
                     $realtime, e.region, region_q);
            errors++;
          end
          region_seen[e.region]++;
          n_checked++;
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("%0t: watchdog expired", $realtime);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    px_d = '0; py_d = '0; ax_d = '0; ay_d = '0; bx_d = '0; by_d = '0;
    phase = 0;
    hold_req = 1'b0;
    hold_cnt = 0;
    quiet_cycles = 0;
    errors = 0;
    n_checked = 0;
    region_seen = '{0, 0, 0};
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed corners
    pending_queries.push_back(make_query(-32768, -32768, -32768, -32768, -32768, -32768));
    pending_queries.push_back(make_query(32767, 32767, 32767, 32767, 32767, 32767));
    pending_queries.push_back(make_query(32767, 32767, -32768, -32768, -32768, -32768));
    pending_queries.push_back(make_query(-32768, 32767, 32767, -32768, 32767, -32768));
    pending_queries.push_back(make_query(32767, -32768, -32768, 32767, 32767, -32768));
    pending_queries.push_back(make_query(-32768, -32768, 32767, 32767, 32767, -32768));
    pending_queries.push_back(make_query(0, 32767, -32768, 0, 32767, 0));
    pending_queries.push_back(make_query(-5, 3, 0, 0, 10, 0));     // behind A
    pending_queries.push_back(make_query(15, -3, 0, 0, 10, 0));    // past B
    pending_queries.push_back(make_query(10, 0, 0, 0, 10, 0));     // projection equals len
    pending_queries.push_back(make_query(7, 7, 0, 0, 10, 3));      // interior, truncation
    pending_queries.push_back(make_query(-7, -7, 0, 0, -10, 3));   // negative step
    pending_queries.push_back(make_query(3, 4, 0, 0, 0, 0));       // degenerate
    pending_queries.push_back(make_query(0, 0, 0, 0, 5, 5));       // point on A
    pending_queries.push_back(make_query(-32768, 32767, 0, 0, 1, 1));

    for (int p = 0; p < 3; p++) begin
      phase = p;
      if (p == 2) hold_req = 1'b1;             // fill the pipe behind a stalled output
      for (int i = 0; i < 500; i++) pending_queries.push_back(random_query());
      wait (pending_queries.size() == 0 && !in_valid && expected_answers.size() == 0);
    end
    repeat (LATENCY + 10) @(posedge clk);

    $display("checked %0d results: region A %0d, region B %0d, interior %0d",
             n_checked, region_seen[0], region_seen[1], region_seen[2]);
    $display("covered corner coordinates, degenerate segments, three idle mixes, long hold-off");
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
